>>> rtl/assert_macros.svh
// Assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/u8v_pkg.sv
// Types, constants and helper functions for the UTF-8 text validator.
package u8v_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CAP_W   = 16;
    localparam int unsigned PEND_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd64;
    localparam logic [CAP_W-1:0] CNT_MAX   = 16'hffff;

    localparam logic [BYTE_W-1:0] B_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] B_DEL     = 8'h7f;
    localparam logic [BYTE_W-1:0] B_CONT_LO = 8'h80;
    localparam logic [BYTE_W-1:0] B_CONT_HI = 8'hbf;
    localparam logic [BYTE_W-1:0] B_2_LO    = 8'hc2;
    localparam logic [BYTE_W-1:0] B_2_HI    = 8'hdf;
    localparam logic [BYTE_W-1:0] B_E0      = 8'he0;
    localparam logic [BYTE_W-1:0] B_ED      = 8'hed;
    localparam logic [BYTE_W-1:0] B_3_HI    = 8'hef;
    localparam logic [BYTE_W-1:0] B_F0      = 8'hf0;
    localparam logic [BYTE_W-1:0] B_F4      = 8'hf4;
    localparam logic [BYTE_W-1:0] B_A0      = 8'ha0;
    localparam logic [BYTE_W-1:0] B_9F      = 8'h9f;
    localparam logic [BYTE_W-1:0] B_90      = 8'h90;
    localparam logic [BYTE_W-1:0] B_8F      = 8'h8f;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    // Allowed range of the next continuation byte
    typedef enum logic [2:0] {
        CLS_PLAIN = 3'd0,   // 80..BF
        CLS_E0    = 3'd1,   // A0..BF
        CLS_ED    = 3'd2,   // 80..9F
        CLS_F0    = 3'd3,   // 90..BF
        CLS_F4    = 3'd4    // 80..8F
    } cont_class_t;

    function automatic logic cont_ok(input logic [BYTE_W-1:0] b, input cont_class_t cls);
        logic ok;
        begin
            unique case (cls)
                CLS_E0:  ok = (b >= B_A0) && (b <= B_CONT_HI);
                CLS_ED:  ok = (b >= B_CONT_LO) && (b <= B_9F);
                CLS_F0:  ok = (b >= B_90) && (b <= B_CONT_HI);
                CLS_F4:  ok = (b >= B_CONT_LO) && (b <= B_8F);
                default: ok = (b >= B_CONT_LO) && (b <= B_CONT_HI);
            endcase
            return ok;
        end
    endfunction

endpackage

>>> rtl/utf8_text_validator.sv
// UTF-8 text validator: top level, input register, check logic and result register.
// Verdict path: the last byte goes through the input register, then the result register.
// Throughput: one byte per cycle sustained; the input register stalls only on a
// last byte while the result register holds an untaken verdict.
// Reset: rst_n clears all sequence state and both valid flags and sets the capacity to 64.
`include "assert_macros.svh"

module utf8_text_validator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // text_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic        s_axis_tuser,   // empty_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] text_valid, [7:1] zero
);

    logic [u8v_pkg::CAP_W-1:0]  cap_reg;

    logic                       in_valid_reg;
    logic [u8v_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_last_reg;
    logic                       in_empty_reg;

    logic [u8v_pkg::PEND_W-1:0] pend_reg, pend_next;
    u8v_pkg::cont_class_t       cls_reg, cls_next;
    logic                       err_reg, err_next;
    logic [u8v_pkg::CAP_W-1:0]  cnt_reg, cnt_next;

    logic                       out_valid_reg;
    logic                       out_data_reg, out_data_next;

    logic                       out_free;
    logic                       proc;
    logic                       in_take;
    logic                       out_load;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || proc;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_load      = proc && in_last_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= u8v_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
    end

    // Per-byte check
    always_comb
    begin
        logic [u8v_pkg::CAP_W-1:0] cnt_inc;
        logic                      err_b;
        logic                      ok;

        pend_next     = pend_reg;
        cls_next      = cls_reg;
        err_next      = err_reg;
        cnt_next      = cnt_reg;
        out_data_next = 1'b0;

        cnt_inc = (cnt_reg == u8v_pkg::CNT_MAX) ? cnt_reg : cnt_reg + 16'd1;
        err_b   = err_reg || (in_byte_reg < u8v_pkg::B_SPACE)
                          || (in_byte_reg == u8v_pkg::B_DEL);
        ok      = 1'b0;

        if (proc && !in_empty_reg)
        begin
            cnt_next = cnt_inc;
            err_next = err_b;
            if (pend_reg != u8v_pkg::PEND_NONE)
            begin
                if (!u8v_pkg::cont_ok(in_byte_reg, cls_reg))
                begin
                    err_next = 1'b1;
                end
                cls_next  = u8v_pkg::CLS_PLAIN;
                pend_next = pend_reg - u8v_pkg::PEND_ONE;
            end
            else
            begin
                priority if (in_byte_reg <= u8v_pkg::B_DEL)
                begin
                    pend_next = u8v_pkg::PEND_NONE;
                end
                else if (in_byte_reg >= u8v_pkg::B_2_LO && in_byte_reg <= u8v_pkg::B_2_HI)
                begin
                    pend_next = u8v_pkg::PEND_ONE;
                    cls_next  = u8v_pkg::CLS_PLAIN;
                end
                else if (in_byte_reg >= u8v_pkg::B_E0 && in_byte_reg <= u8v_pkg::B_3_HI)
                begin
                    pend_next = u8v_pkg::PEND_TWO;
                    cls_next  = (in_byte_reg == u8v_pkg::B_E0) ? u8v_pkg::CLS_E0 :
                                (in_byte_reg == u8v_pkg::B_ED) ? u8v_pkg::CLS_ED :
                                                                 u8v_pkg::CLS_PLAIN;
                end
                else if (in_byte_reg >= u8v_pkg::B_F0 && in_byte_reg <= u8v_pkg::B_F4)
                begin
                    pend_next = u8v_pkg::PEND_THREE;
                    cls_next  = (in_byte_reg == u8v_pkg::B_F0) ? u8v_pkg::CLS_F0 :
                                (in_byte_reg == u8v_pkg::B_F4) ? u8v_pkg::CLS_F4 :
                                                                 u8v_pkg::CLS_PLAIN;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            ok = !err_next && (pend_next == u8v_pkg::PEND_NONE)
                 && (cnt_next != '0) && (cnt_next < cap_reg);
        end

        if (out_load)
        begin
            out_data_next = ok;
            pend_next     = u8v_pkg::PEND_NONE;
            cls_next      = u8v_pkg::CLS_PLAIN;
            err_next      = 1'b0;
            cnt_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= u8v_pkg::PEND_NONE;
            cls_reg  <= u8v_pkg::CLS_PLAIN;
            err_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            cls_reg  <= cls_next;
            err_reg  <= err_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `ASSERT_IMPLIES(a_cls_needs_pend, cls_reg != u8v_pkg::CLS_PLAIN,
        pend_reg == u8v_pkg::PEND_TWO || pend_reg == u8v_pkg::PEND_THREE)
    `ASSERT_NEXT(a_last_clears, out_load,
        out_valid_reg && pend_reg == u8v_pkg::PEND_NONE && !err_reg && cnt_reg == '0)
    `ASSERT_NEXT(a_in_hold, in_valid_reg && !proc,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg))
    `ASSERT_IMPLIES(a_stall_only_on_last, in_valid_reg && !proc, in_last_reg && !out_free)

endmodule
